/* rtl/core/tksp_pkg.sv */
package tksp_pkg;

    // Key codes carried in the key_code field of a result.
    localparam logic [3:0] KEY_SPACE     = 4'd0;
    localparam logic [3:0] KEY_BACKSPACE = 4'd1;
    localparam logic [3:0] KEY_ENTER     = 4'd2;
    localparam logic [3:0] KEY_TAB       = 4'd3;
    localparam logic [3:0] KEY_UP        = 4'd4;
    localparam logic [3:0] KEY_DELETE    = 4'd8;
    localparam logic [3:0] KEY_CHAR      = 4'd9;
    localparam logic [3:0] KEY_UNKNOWN   = 4'd10;

    // Byte values that the parser recognizes.
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_THREE = 8'h33;
    localparam logic [7:0] BYTE_A     = 8'h41;
    localparam logic [7:0] BYTE_D     = 8'h44;
    localparam logic [7:0] BYTE_LBRK  = 8'h5B;
    localparam logic [7:0] BYTE_TILDE = 8'h7E;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;

    // Parser modes, one-hot.
    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_ESC  = 5'b00010,
        MODE_CSI  = 5'b00100,
        MODE_CSI3 = 5'b01000,
        MODE_UTF8 = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in;

    typedef struct packed {
        logic [3:0]  key_code;
        logic [31:0] char_bytes;
        logic [2:0]  char_length;
    } t_result;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] held;
        logic [2:0]  expected;
        logic [2:0]  seen;
    } t_state;

    // Decoder outputs: up to two results (slot 0 first) and the next state.
    typedef struct packed {
        logic [1:0] valid;
        t_result    res0;
        t_result    res1;
        t_state     next;
    } t_dec;

endpackage

/* rtl/core/tksp_decode.sv */
module tksp_decode (
    input  tksp_pkg::t_state i_state,
    input  tksp_pkg::t_in    i_item,
    output tksp_pkg::t_dec   o_dec
);

    logic [7:0]        b;
    logic              eob;
    logic [2:0]        size;
    logic              is_ctrl;
    logic [7:0]        arrow_off;
    logic [31:0]       held_new;
    logic [2:0]        seen_new;
    tksp_pkg::t_result r_none;
    tksp_pkg::t_result r_unknown;
    tksp_pkg::t_result r_byte;
    tksp_pkg::t_result r_three;
    logic              cp_valid;
    tksp_pkg::t_result cp_res;
    tksp_pkg::t_state  cp_next;
    logic              f_valid;
    tksp_pkg::t_result f_res;
    tksp_pkg::t_state  f_next;

    assign b   = i_item.in_byte;
    assign eob = i_item.end_of_buffer;

    // UTF-8 lead byte length; zero marks a bad lead.
    always_comb begin
        if (b[7] == 1'b0) begin
            size = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            size = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            size = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            size = 3'd4;
        end else begin
            size = 3'd0;
        end
    end

    assign is_ctrl   = (b < tksp_pkg::BYTE_SPACE) || (b == tksp_pkg::BYTE_DEL);
    assign arrow_off = b - tksp_pkg::BYTE_A;

    // Fixed result patterns.
    always_comb begin
        r_none      = '0;
        r_unknown   = '0;
        r_unknown.key_code = tksp_pkg::KEY_UNKNOWN;
        r_byte      = '0;
        r_byte.key_code    = tksp_pkg::KEY_CHAR;
        r_byte.char_bytes  = {24'd0, b};
        r_byte.char_length = 3'd1;
        r_three     = '0;
        r_three.key_code    = tksp_pkg::KEY_CHAR;
        r_three.char_bytes  = {24'd0, tksp_pkg::BYTE_THREE};
        r_three.char_length = 3'd1;
    end

    // Byte taken as the start of a character.
    always_comb begin
        cp_next      = i_state;
        cp_next.mode = tksp_pkg::MODE_IDLE;
        cp_valid     = 1'b1;
        cp_res       = r_unknown;
        if (is_ctrl || size == 3'd0) begin
            cp_res = r_unknown;
        end else if (size == 3'd1 || eob) begin
            cp_res = r_byte;
        end else begin
            cp_valid         = 1'b0;
            cp_res           = r_none;
            cp_next.mode     = tksp_pkg::MODE_UTF8;
            cp_next.held     = {24'd0, b};
            cp_next.expected = size;
            cp_next.seen     = 3'd1;
        end
    end

    // Byte decoded from the idle mode.
    always_comb begin
        f_next      = i_state;
        f_next.mode = tksp_pkg::MODE_IDLE;
        f_valid     = 1'b1;
        f_res       = r_none;
        if (b == tksp_pkg::BYTE_SPACE) begin
            f_res.key_code = tksp_pkg::KEY_SPACE;
        end else if (b == tksp_pkg::BYTE_BS || b == tksp_pkg::BYTE_DEL) begin
            f_res.key_code = tksp_pkg::KEY_BACKSPACE;
        end else if (b == tksp_pkg::BYTE_LF) begin
            f_res.key_code = tksp_pkg::KEY_ENTER;
        end else if (b == tksp_pkg::BYTE_TAB) begin
            f_res.key_code = tksp_pkg::KEY_TAB;
        end else if (b == tksp_pkg::BYTE_ESC) begin
            if (eob) begin
                f_res = r_unknown;
            end else begin
                f_valid     = 1'b0;
                f_next.mode = tksp_pkg::MODE_ESC;
            end
        end else begin
            f_valid = cp_valid;
            f_res   = cp_res;
            f_next  = cp_next;
        end
    end

    // Next character byte merged into the held bytes.
    assign held_new = i_state.held | ({24'd0, b} << {i_state.seen[1:0], 3'b000});
    assign seen_new = i_state.seen + 3'd1;

    // Mode dispatch.
    always_comb begin
        o_dec       = '0;
        o_dec.next  = i_state;
        case (i_state.mode)
            tksp_pkg::MODE_ESC: begin
                if (b == tksp_pkg::BYTE_LBRK) begin
                    o_dec.next.mode = eob ? tksp_pkg::MODE_IDLE : tksp_pkg::MODE_CSI;
                end else begin
                    o_dec.valid = {f_valid, 1'b1};
                    o_dec.res0  = r_unknown;
                    o_dec.res1  = f_res;
                    o_dec.next  = f_next;
                end
            end
            tksp_pkg::MODE_CSI: begin
                if (b >= tksp_pkg::BYTE_A && b <= tksp_pkg::BYTE_D) begin
                    o_dec.valid          = 2'b01;
                    o_dec.res0.key_code  = tksp_pkg::KEY_UP + {2'b00, arrow_off[1:0]};
                    o_dec.next.mode      = tksp_pkg::MODE_IDLE;
                end else if (b == tksp_pkg::BYTE_THREE) begin
                    if (eob) begin
                        o_dec.valid     = 2'b01;
                        o_dec.res0      = r_three;
                        o_dec.next.mode = tksp_pkg::MODE_IDLE;
                    end else begin
                        o_dec.next.mode = tksp_pkg::MODE_CSI3;
                    end
                end else begin
                    o_dec.valid = {1'b0, cp_valid};
                    o_dec.res0  = cp_res;
                    o_dec.next  = cp_next;
                end
            end
            tksp_pkg::MODE_CSI3: begin
                if (b == tksp_pkg::BYTE_TILDE) begin
                    o_dec.valid         = 2'b01;
                    o_dec.res0.key_code = tksp_pkg::KEY_DELETE;
                    o_dec.next.mode     = tksp_pkg::MODE_IDLE;
                end else begin
                    o_dec.valid = {f_valid, 1'b1};
                    o_dec.res0  = r_three;
                    o_dec.res1  = f_res;
                    o_dec.next  = f_next;
                end
            end
            tksp_pkg::MODE_UTF8: begin
                if (i_state.seen < 3'd1 || i_state.seen > 3'd3) begin
                    o_dec.valid = {1'b0, f_valid};
                    o_dec.res0  = f_res;
                    o_dec.next  = f_next;
                end else begin
                    o_dec.next.held = held_new;
                    o_dec.next.seen = seen_new;
                    if (seen_new >= i_state.expected || eob) begin
                        o_dec.valid            = 2'b01;
                        o_dec.res0.key_code    = tksp_pkg::KEY_CHAR;
                        o_dec.res0.char_bytes  = held_new;
                        o_dec.res0.char_length = seen_new;
                        o_dec.next.mode        = tksp_pkg::MODE_IDLE;
                    end
                end
            end
            default: begin
                o_dec.valid = {1'b0, f_valid};
                o_dec.res0  = f_res;
                o_dec.next  = f_next;
            end
        endcase
    end

endmodule

/* rtl/core/tksp_out_queue.sv */
module tksp_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push,
    input  tksp_pkg::t_result i_res0,
    input  tksp_pkg::t_result i_res1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output tksp_pkg::t_result o_data,
    output logic [2:0]        o_count
);

    localparam int Depth = 4;

    tksp_pkg::t_result r_mem [Depth];
    logic [1:0]        r_wr;
    logic [1:0]        r_rd;
    logic [2:0]        r_count;
    logic [2:0]        n_count;
    logic              pop;
    logic [2:0]        push_n;

    assign pop     = (r_count != 3'd0) && i_ready;
    assign push_n  = {2'b00, i_push[0]} + {2'b00, i_push[1]};
    assign n_count = r_count + push_n - {2'b00, pop};

    // Room for two results once this cycle's transfer, if any, is counted.
    assign o_room  = (r_count <= 3'd2) || ((r_count == 3'd3) && pop);
    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    // Pointer and count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push_n[1:0];
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= n_count;
        end
    end

    // Result storage; slot 1 is used only with slot 0.
    always_ff @(posedge i_clk) begin
        if (i_push[0]) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push[1]) begin
            r_mem[r_wr + 2'd1] <= i_res1;
        end
    end

endmodule

/* rtl/core/terminal_key_sequence_parser_top.sv */
// An accepted byte is registered, decoded combinationally and written into the
// result queue, a second event from the same byte behind the first. Throughput:
// one byte per cycle while the queue has room; the output port moves one event
// per cycle, so bytes that yield two events are limited by the four-entry queue.
// Reset (synchronous, active low) idles the parser and empties the queue.
module terminal_key_sequence_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tksp_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tksp_pkg::t_result o_out_data
);

    logic             r_in_valid;
    tksp_pkg::t_in    r_in;
    tksp_pkg::t_state r_state;
    tksp_pkg::t_dec   dec;
    logic             room;
    logic             commit;
    logic [1:0]       push;
    logic [2:0]       q_count;

    assign commit     = r_in_valid && room;
    assign o_in_ready = !r_in_valid || commit;
    assign push       = commit ? dec.valid : 2'b00;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Parser state advances when a byte is decoded into the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= tksp_pkg::MODE_IDLE;
            r_state.held     <= '0;
            r_state.expected <= '0;
            r_state.seen     <= '0;
        end else if (commit) begin
            r_state <= dec.next;
        end
    end

    tksp_decode u_decode (
        .i_state (r_state),
        .i_item  (r_in),
        .o_dec   (dec)
    );

    tksp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (dec.res0),
        .i_res1  (dec.res1),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data),
        .o_count (q_count)
    );

    // The queue never overfills.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= 3'd4)
        else $error("result queue overflow");

    // A second result is never produced without a first.
    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec.valid[1] |-> dec.valid[0])
        else $error("second result without first");

    // While collecting a character, the byte count stays within a legal range.
    a_utf8_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == tksp_pkg::MODE_UTF8) |->
            (r_state.seen >= 3'd1 && r_state.seen <= 3'd3))
        else $error("UTF-8 byte count out of range");

    // A character event carries bytes; any other event carries none.
    a_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.key_code == tksp_pkg::KEY_CHAR) ==
                         (o_out_data.char_length != 3'd0)))
        else $error("character length mismatch");

endmodule

/* test/tksp_key_checker.sv */
`timescale 1ns / 1ps

module tksp_key_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  tksp_pkg::t_in     i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  tksp_pkg::t_result i_out_data,
    output int                o_fail_count,
    output int                o_keys_pending
);
    import tksp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the parser state.
    t_mode       parse_state;
    logic [31:0] utf8_acc;
    logic [2:0]  utf8_want;
    logic [2:0]  utf8_got;

    // Key events predicted but not yet seen on the output.
    t_result     pending_keys[$];
    int          fail_total;

    initial begin
        parse_state    = MODE_IDLE;
        utf8_acc       = '0;
        utf8_want      = '0;
        utf8_got       = '0;
        fail_total     = 0;
        o_keys_pending = 0;
    end

    assign o_fail_count = fail_total;

    task automatic push_key(input logic [3:0] code, input logic [31:0] bytes,
                            input logic [2:0] len);
        t_result r;
        r.key_code    = code;
        r.char_bytes  = bytes;
        r.char_length = len;
        pending_keys.push_back(r);
    endtask

    // Length that a UTF-8 lead byte announces; zero for a bad lead.
    function automatic logic [2:0] utf8_lead_len(input logic [7:0] b);
        if (b[7] == 1'b0)          return 3'd1;
        if (b[7:5] == 3'b110)      return 3'd2;
        if (b[7:4] == 4'b1110)     return 3'd3;
        if (b[7:3] == 5'b11110)    return 3'd4;
        return 3'd0;
    endfunction

    // Treat the byte as the start of a character.
    task automatic decode_as_char(input logic [7:0] b, input logic eob);
        logic [2:0] len;
        len         = utf8_lead_len(b);
        parse_state = MODE_IDLE;
        if (b < BYTE_SPACE || b == BYTE_DEL) begin
            push_key(KEY_UNKNOWN, '0, '0);
        end else if (len == 3'd0) begin
            push_key(KEY_UNKNOWN, '0, '0);
        end else if (len == 3'd1 || eob) begin
            push_key(KEY_CHAR, {24'd0, b}, 3'd1);
        end else begin
            utf8_acc    = {24'd0, b};
            utf8_want   = len;
            utf8_got    = 3'd1;
            parse_state = MODE_UTF8;
        end
    endtask

    // Decode the byte as if the parser were idle.
    task automatic decode_fresh(input logic [7:0] b, input logic eob);
        parse_state = MODE_IDLE;
        if (b == BYTE_SPACE) begin
            push_key(KEY_SPACE, '0, '0);
        end else if (b == BYTE_BS || b == BYTE_DEL) begin
            push_key(KEY_BACKSPACE, '0, '0);
        end else if (b == BYTE_LF) begin
            push_key(KEY_ENTER, '0, '0);
        end else if (b == BYTE_TAB) begin
            push_key(KEY_TAB, '0, '0);
        end else if (b == BYTE_ESC) begin
            if (eob) begin
                push_key(KEY_UNKNOWN, '0, '0);
            end else begin
                parse_state = MODE_ESC;
            end
        end else begin
            decode_as_char(b, eob);
        end
    endtask

    // Advance the shadow parser by one byte and queue the key events it yields.
    task automatic predict_keys(input logic [7:0] b, input logic eob);
        logic [7:0] arrow_ofs;
        arrow_ofs = b - BYTE_A;
        case (parse_state)
            MODE_ESC: begin
                if (b == BYTE_LBRK) begin
                    parse_state = eob ? MODE_IDLE : MODE_CSI;
                end else begin
                    // A lone escape is reported, then the byte is decoded anew.
                    push_key(KEY_UNKNOWN, '0, '0);
                    decode_fresh(b, eob);
                end
            end
            MODE_CSI: begin
                if (b >= BYTE_A && b <= BYTE_D) begin
                    parse_state = MODE_IDLE;
                    push_key(KEY_UP + arrow_ofs[3:0], '0, '0);
                end else if (b == BYTE_THREE) begin
                    if (eob) begin
                        parse_state = MODE_IDLE;
                        push_key(KEY_CHAR, {24'd0, b}, 3'd1);
                    end else begin
                        parse_state = MODE_CSI3;
                    end
                end else begin
                    decode_as_char(b, eob);
                end
            end
            MODE_CSI3: begin
                if (b == BYTE_TILDE) begin
                    parse_state = MODE_IDLE;
                    push_key(KEY_DELETE, '0, '0);
                end else begin
                    push_key(KEY_CHAR, {24'd0, BYTE_THREE}, 3'd1);
                    decode_fresh(b, eob);
                end
            end
            MODE_UTF8: begin
                if (utf8_got < 3'd1 || utf8_got > 3'd3) begin
                    decode_fresh(b, eob);
                end else begin
                    utf8_acc = utf8_acc | ({24'd0, b} << (8 * utf8_got));
                    utf8_got = utf8_got + 3'd1;
                    if (utf8_got >= utf8_want || eob) begin
                        parse_state = MODE_IDLE;
                        push_key(KEY_CHAR, utf8_acc, utf8_got);
                    end
                end
            end
            default: begin
                decode_fresh(b, eob);
            end
        endcase
    endtask

    // Compare output transfers first, then predict from the input transfer.
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            parse_state = MODE_IDLE;
            utf8_acc    = '0;
            utf8_want   = '0;
            utf8_got    = '0;
            pending_keys.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_keys.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT) begin
                        $display("unexpected key event: key=%0d bytes=%h len=%0d",
                                 i_out_data.key_code, i_out_data.char_bytes,
                                 i_out_data.char_length);
                    end
                end else begin
                    want = pending_keys.pop_front();
                    if (i_out_data.key_code !== want.key_code ||
                        i_out_data.char_bytes !== want.char_bytes ||
                        i_out_data.char_length !== want.char_length) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("key mismatch: expected key=%0d bytes=%h len=%0d, got key=%0d bytes=%h len=%0d",
                                     want.key_code, want.char_bytes, want.char_length,
                                     i_out_data.key_code, i_out_data.char_bytes,
                                     i_out_data.char_length);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_keys(i_in_data.in_byte, i_in_data.end_of_buffer);
            end
        end
        o_keys_pending = pending_keys.size();
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tksp_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_BYTES   = 1600;
    localparam int SEGMENT_BYTES  = 200;
    localparam int HOLD_AT_BYTE   = 500;
    localparam int HOLD_SPAN      = 200;
    localparam int PAUSE_AT_BYTE  = 1000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int DIRECTED_COUNT = 32;
    localparam logic EOB  = 1'b1;
    localparam logic MORE = 1'b0;

    logic    i_clk;
    logic    i_rst_n;
    logic    byte_valid;
    logic    byte_ready;
    t_in     byte_data;
    logic    key_valid;
    logic    key_ready;
    t_result key_data;

    int      fail_count;
    int      keys_pending;
    int      cycle_count  = 0;
    int      bytes_sent   = 0;
    logic    byte_took    = 1'b0;
    bit      tx_idle_on   = 1'b1;
    bit      rx_idle_on   = 1'b1;
    bit      rx_hold_req  = 1'b0;

    logic [8:0] directed_bytes [0:DIRECTED_COUNT-1];

    terminal_key_sequence_parser_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (byte_valid),
        .o_in_ready  (byte_ready),
        .i_in_data   (byte_data),
        .o_out_valid (key_valid),
        .i_out_ready (key_ready),
        .o_out_data  (key_data)
    );

    tksp_key_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (byte_valid),
        .i_in_ready     (byte_ready),
        .i_in_data      (byte_data),
        .i_out_valid    (key_valid),
        .i_out_ready    (key_ready),
        .i_out_data     (key_data),
        .o_fail_count   (fail_count),
        .o_keys_pending (keys_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Record each input transfer so the sender can see it at the falling edge.
    always @(posedge i_clk) begin
        byte_took <= i_rst_n && byte_valid && byte_ready;
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic rand_eob(input int one_in);
        return $urandom_range(1, one_in) == 1;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        key_ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                stall_left  = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                key_ready = 1'b0;
                stall_left--;
            end else begin
                key_ready = 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the transfer happens.
    task automatic send_key_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            byte_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_valid = 1'b1;
        byte_data  = '{in_byte: b, end_of_buffer: eob};
        do @(negedge i_clk); while (!byte_took);
        bytes_sent++;
    endtask

    task automatic wait_keys_drained();
        byte_valid = 1'b0;
        while (keys_pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] utf8_lead(input int len);
        if (len == 2) return {3'b110, 5'($urandom)};
        if (len == 3) return {4'b1110, 4'($urandom)};
        return {5'b11110, 3'($urandom)};
    endfunction

    // One key sequence: mostly well formed, some broken, some raw noise.
    task automatic send_random_token();
        int pick;
        int len;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_key_byte(8'($urandom_range(8'h21, 8'h7E)), rand_eob(10));
        end else if (pick < 35) begin
            case ($urandom_range(0, 4))
                0: send_key_byte(BYTE_SPACE, rand_eob(10));
                1: send_key_byte(BYTE_BS, rand_eob(10));
                2: send_key_byte(BYTE_DEL, rand_eob(10));
                3: send_key_byte(BYTE_LF, rand_eob(10));
                default: send_key_byte(BYTE_TAB, rand_eob(10));
            endcase
        end else if (pick < 50) begin
            send_key_byte(BYTE_ESC, rand_eob(25));
            send_key_byte(BYTE_LBRK, rand_eob(25));
            send_key_byte(BYTE_A + 8'($urandom_range(0, 3)), rand_eob(10));
        end else if (pick < 58) begin
            send_key_byte(BYTE_ESC, rand_eob(25));
            send_key_byte(BYTE_LBRK, rand_eob(25));
            send_key_byte(BYTE_THREE, rand_eob(25));
            send_key_byte(BYTE_TILDE, rand_eob(10));
        end else if (pick < 73) begin
            len = $urandom_range(2, 4);
            send_key_byte(utf8_lead(len), rand_eob(30));
            for (int i = 1; i < len; i++) begin
                send_key_byte({2'b10, 6'($urandom)}, (i == len - 1) ? rand_eob(10)
                                                                   : rand_eob(30));
            end
        end else if (pick < 81) begin
            // Escape prefix followed by something unexpected.
            send_key_byte(BYTE_ESC, MORE);
            case ($urandom_range(0, 2))
                0: begin
                    send_key_byte(8'($urandom), rand_eob(8));
                end
                1: begin
                    send_key_byte(BYTE_LBRK, MORE);
                    send_key_byte(8'($urandom), rand_eob(8));
                end
                default: begin
                    send_key_byte(BYTE_LBRK, MORE);
                    send_key_byte(BYTE_THREE, MORE);
                    send_key_byte(8'($urandom), rand_eob(8));
                end
            endcase
        end else if (pick < 88) begin
            // Character cut short by the end of the buffer.
            len = $urandom_range(2, 4);
            cut = $urandom_range(1, len - 1);
            send_key_byte(utf8_lead(len), (cut == 1) ? EOB : MORE);
            for (int i = 1; i < cut; i++) begin
                send_key_byte({2'b10, 6'($urandom)}, (i == cut - 1) ? EOB : MORE);
            end
        end else begin
            send_key_byte(8'($urandom), rand_eob(8));
        end
    endtask

    // Stimulus and verdict.
    initial begin : sender
        int  seg;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        i_rst_n    = 1'b0;
        byte_valid = 1'b0;
        byte_data  = '0;
        directed_bytes = '{
            {8'h00, MORE}, {8'hFF, MORE}, {BYTE_SPACE, MORE}, {BYTE_BS, MORE},
            {BYTE_DEL, MORE}, {BYTE_LF, MORE}, {BYTE_TAB, MORE},
            {BYTE_ESC, MORE}, {BYTE_LBRK, MORE}, {BYTE_A, MORE},
            {BYTE_ESC, MORE}, {BYTE_LBRK, MORE}, {BYTE_THREE, MORE}, {BYTE_TILDE, MORE},
            {BYTE_ESC, MORE}, {8'h78, MORE},
            {BYTE_ESC, EOB},
            {BYTE_ESC, MORE}, {BYTE_LBRK, EOB},
            {BYTE_ESC, MORE}, {BYTE_LBRK, MORE}, {BYTE_THREE, MORE}, {8'h71, MORE},
            {BYTE_ESC, MORE}, {BYTE_LBRK, MORE}, {8'h7A, MORE},
            {8'hF0, MORE}, {8'h9F, MORE}, {8'h98, MORE}, {8'h80, MORE},
            {8'hE2, MORE}, {8'h82, EOB}
        };
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed bytes: edit keys, escape sequences and their broken forms, and UTF-8.
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_key_byte(directed_bytes[i][8:1], directed_bytes[i][0]);
        end
        wait_keys_drained();

        // Random sequences, cycling through idle patterns on both sides.
        while (bytes_sent < RANDOM_BYTES + DIRECTED_COUNT) begin
            seg        = bytes_sent / SEGMENT_BYTES;
            tx_idle_on = (seg % 4 == 0) || (seg % 4 == 1);
            rx_idle_on = (seg % 4 == 0) || (seg % 4 == 2);
            if (!hold_done && bytes_sent >= HOLD_AT_BYTE) begin
                rx_hold_req = 1'b1;
                hold_done   = 1'b1;
            end
            if (bytes_sent >= HOLD_AT_BYTE && bytes_sent < HOLD_AT_BYTE + HOLD_SPAN) begin
                tx_idle_on = 1'b0;
            end
            if (!pause_done && bytes_sent >= PAUSE_AT_BYTE) begin
                wait_keys_drained();
                pause_done = 1'b1;
            end
            send_random_token();
        end

        wait_keys_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && keys_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
